### rtl/core/orwa_pkg.sv
// Package: shared constants, derived widths and the sequencer state type.
package orwa_pkg;

  localparam int WindowLen    = 10;
  localparam int MvFullScale  = 3000;
  localparam int PercentScale = 100;

  localparam int MvW      = 12;
  localparam int PeriodW  = 16;
  localparam int PercentW = 7;
  localparam int CountW   = 4;

  localparam int AddrW  = $clog2(WindowLen);
  localparam int IdxW   = $clog2(WindowLen + 1);
  localparam int KeptW  = $clog2(WindowLen + 1);
  localparam int SumW   = $clog2(MvFullScale * WindowLen + 1);
  localparam int BandW  = $clog2(11 * MvFullScale + 1);

  // sum / WindowLen as multiply by a rounded-up reciprocal
  localparam int MeanShift = SumW + $clog2(WindowLen);
  localparam logic [MeanShift-1:0] MeanRecip =
      MeanShift'((2 ** MeanShift + WindowLen - 1) / WindowLen);

  // 100 * f / 3000 == f / 30
  localparam int DutyDiv   = MvFullScale / PercentScale;
  localparam int DutyShift = MvW + $clog2(DutyDiv);
  localparam logic [DutyShift-1:0] DutyRecip =
      DutyShift'((2 ** DutyShift + DutyDiv - 1) / DutyDiv);

  // period * duty / 100
  localparam int PulseW     = PeriodW + PercentW;
  localparam int PulseShift = PulseW + PercentW;
  localparam logic [PulseShift-1:0] PulseRecip =
      PulseShift'((2 ** PulseShift + PercentScale - 1) / PercentScale);

  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(1000);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MEAN,
    ST_BAND,
    ST_KEEP,
    ST_DIV,
    ST_DUTY,
    ST_PULSE,
    ST_SCALE
  } orwa_state_e;

endpackage

### rtl/core/orwa_div.sv
// Serial restoring divider: kept-entry sum over kept-entry count, one bit a cycle.
module orwa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [orwa_pkg::SumW-1:0]  dividend_i,
  input  logic [orwa_pkg::KeptW-1:0] divisor_i,
  output logic                      done_o,
  output logic [orwa_pkg::SumW-1:0]  quotient_o
);
  import orwa_pkg::*;

  localparam int CntW = $clog2(SumW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] quo_q;
  logic [KeptW-1:0] rem_q;
  logic [KeptW-1:0] dvs_q;

  logic [KeptW:0] rem_sh;
  logic [KeptW:0] rem_sub;
  logic           ge;

  assign rem_sh  = {rem_q, quo_q[SumW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(SumW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SumW-2:0], ge};
      rem_q <= ge ? rem_sub[KeptW-1:0] : rem_sh[KeptW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/core/outlier_rejecting_window_average.sv
// Top level: outlier-rejecting window average with PWM duty and pulse width.
//
// Each accepted sample (millivolts, clamped to 3000) overwrites the oldest entry
// of a ten-entry window held in a single-port synchronous RAM (circular write
// pointer, per-entry valid bits so unwritten entries read as zero after reset).
// A sequencer then makes two read passes over the RAM: the first sums all
// entries and takes the truncated mean, the second keeps entries with
// 9*mean < 10*x < 11*mean and sums them. The kept sum is divided by the kept
// count in a one-bit-per-cycle divider; with nothing kept the previous filtered
// value is repeated and all_outliers is set. Duty percent (filtered/30) and
// pulse width (period*duty/100) come from reciprocal multiplies, one per cycle unless the output stalls.
// The item rate is set by the two passes through the one RAM read port and by
// the serial divider, when the output is taken promptly. With nothing kept the
// divider is skipped. One item is worked on at a time; in_stall_o is low only
// while the sequencer is idle. The result sits in an output register, so the
// next sample is accepted while an earlier result still waits. The PWM
// period register is written through the cfg port (always ready) and must only
// be changed while no item is in flight.
module outlier_rejecting_window_average (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [orwa_pkg::MvW-1:0]      sample_mv_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [orwa_pkg::MvW-1:0]      filtered_mv_o,
  output logic [orwa_pkg::MvW-1:0]      window_mean_mv_o,
  output logic [orwa_pkg::CountW-1:0]   kept_count_o,
  output logic                         all_outliers_o,
  output logic [orwa_pkg::PercentW-1:0] duty_percent_o,
  output logic [orwa_pkg::PeriodW-1:0]  pulse_width_us_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [orwa_pkg::PeriodW-1:0]  cfg_pwm_period_us_i
);
  import orwa_pkg::*;

  localparam int MeanProdW  = SumW + MeanShift;
  localparam int DutyProdW  = MvW + DutyShift;
  localparam int PulseProdW = PulseW + PulseShift;

  orwa_state_e state_q, state_d;

  // window RAM and its valid bits
  logic [MvW-1:0]       win_mem [WindowLen];
  logic [WindowLen-1:0] vld_q;
  logic [AddrW-1:0]     wr_ptr_q;
  logic [MvW-1:0]       rd_data_q;
  logic                 rd_ok_q;
  logic                 rd_pend_q;

  logic                 in_acc;
  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic [MvW-1:0]       x_clamp;
  logic [MvW-1:0]       ent;

  logic [IdxW-1:0]      idx_q;
  logic [SumW-1:0]      sum_q;
  logic [MvW-1:0]       mean_q;
  logic [SumW-1:0]      ksum_q;
  logic [KeptW-1:0]     kept_q;
  logic [MvW-1:0]       filt_q;
  logic [MvW-1:0]       held_q;
  logic                 allout_q;
  logic [PercentW-1:0]  duty_q;
  logic [PulseW-1:0]    pprod_q;
  logic [PeriodW-1:0]   period_q;

  logic                 div_start;
  logic                 div_done;
  logic [SumW-1:0]      div_quo;

  logic                 out_load;
  logic [MeanProdW-1:0] mean_prod;
  logic [DutyProdW-1:0] duty_prod;
  logic [PulseProdW-1:0] pulse_prod;
  logic [BandW-1:0]     ten_x, m9, m11;
  logic                 in_band;
  logic [KeptW+3:0]     kept_wide;

  logic                 out_valid_q;
  logic [MvW-1:0]       out_filt_q;
  logic [MvW-1:0]       out_mean_q;
  logic [CountW-1:0]    out_kept_q;
  logic                 out_allout_q;
  logic [PercentW-1:0]  out_duty_q;
  logic [PeriodW-1:0]   out_pulse_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign x_clamp = (sample_mv_i > MvW'(MvFullScale)) ? MvW'(MvFullScale) : sample_mv_i;
  assign rd_addr = idx_q[AddrW-1:0];
  assign ent     = rd_ok_q ? rd_data_q : '0;

  // band test: 9*m < 10*x < 11*m
  assign ten_x   = BandW'(ent) * BandW'(10);
  assign m9      = BandW'(mean_q) * BandW'(9);
  assign m11     = BandW'(mean_q) * BandW'(11);
  assign in_band = (ten_x < m11) && (ten_x > m9);

  assign mean_prod  = MeanProdW'(sum_q) * MeanProdW'(MeanRecip);
  assign duty_prod  = DutyProdW'(filt_q) * DutyProdW'(DutyRecip);
  assign pulse_prod = PulseProdW'(pprod_q) * PulseProdW'(PulseRecip);
  assign kept_wide  = (KeptW + 4)'(kept_q);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_SUM;
      ST_SUM:   if (idx_q == IdxW'(WindowLen)) state_d = ST_MEAN;
      ST_MEAN:  state_d = ST_BAND;
      ST_BAND:  if (idx_q == IdxW'(WindowLen)) state_d = ST_KEEP;
      ST_KEEP:  state_d = (kept_q == '0) ? ST_DUTY : ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_DUTY;
      ST_DUTY:  state_d = ST_PULSE;
      ST_PULSE: state_d = ST_SCALE;
      ST_SCALE: if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_SUM, ST_BAND: rd_en = idx_q < IdxW'(WindowLen);
      ST_KEEP:  div_start = kept_q != '0;
      ST_SCALE: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- window RAM ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      win_mem[wr_ptr_q] <= x_clamp;
    end
    if (rd_en) begin
      rd_data_q <= win_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      wr_ptr_q  <= '0;
      rd_ok_q   <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= rd_en;
      if (rd_en) begin
        rd_ok_q <= vld_q[rd_addr];
      end
      if (in_acc) begin
        vld_q[wr_ptr_q] <= 1'b1;
        wr_ptr_q <= (wr_ptr_q == AddrW'(WindowLen - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        idx_q <= '0;
        sum_q <= '0;
      end
      ST_SUM: begin
        if (rd_en) idx_q <= idx_q + 1'b1;
        if (rd_pend_q) sum_q <= sum_q + SumW'(ent);
      end
      ST_MEAN: begin
        mean_q <= MvW'(mean_prod >> MeanShift);
        idx_q  <= '0;
        ksum_q <= '0;
        kept_q <= '0;
      end
      ST_BAND: begin
        if (rd_en) idx_q <= idx_q + 1'b1;
        if (rd_pend_q && in_band) begin
          ksum_q <= ksum_q + SumW'(ent);
          kept_q <= kept_q + 1'b1;
        end
      end
      ST_KEEP: begin
        allout_q <= kept_q == '0;
        filt_q   <= held_q;
      end
      ST_DIV: begin
        if (div_done) filt_q <= MvW'(div_quo);
      end
      ST_DUTY:  duty_q  <= PercentW'(duty_prod >> DutyShift);
      ST_PULSE: pprod_q <= PulseW'(period_q) * PulseW'(duty_q);
      default: ;
    endcase
  end

  // held value and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      period_q <= PeriodReset;
    end else begin
      if (state_q == ST_DIV && div_done) held_q <= MvW'(div_quo);
      if (cfg_valid_i && cfg_ready_o) period_q <= cfg_pwm_period_us_i;
    end
  end

  orwa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ksum_q),
    .divisor_i  (kept_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_filt_q   <= filt_q;
      out_mean_q   <= mean_q;
      out_kept_q   <= (kept_wide > (KeptW + 4)'(15)) ? CountW'(15) : kept_wide[CountW-1:0];
      out_allout_q <= allout_q;
      out_duty_q   <= duty_q;
      out_pulse_q  <= PeriodW'(pulse_prod >> PulseShift);
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign filtered_mv_o    = out_filt_q;
  assign window_mean_mv_o = out_mean_q;
  assign kept_count_o     = out_kept_q;
  assign all_outliers_o   = out_allout_q;
  assign duty_percent_o   = out_duty_q;
  assign pulse_width_us_o = out_pulse_q;

endmodule

### rtl/core/orwa_chk.sv
// Checker: port-level assertions on the top level, attached by bind.
module orwa_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [orwa_pkg::MvW-1:0]      filtered_mv_o,
  input logic [orwa_pkg::MvW-1:0]      window_mean_mv_o,
  input logic [orwa_pkg::CountW-1:0]   kept_count_o,
  input logic                         all_outliers_o,
  input logic [orwa_pkg::PercentW-1:0] duty_percent_o,
  input logic [orwa_pkg::PeriodW-1:0]  pulse_width_us_o
);
  import orwa_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_mv_o)
      && $stable(pulse_width_us_o))
    else $error("output item changed while stalled");

  // one item in flight: stall rises right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while busy");

  // all_outliers flag agrees with the kept count
  a_allout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> all_outliers_o == (kept_count_o == '0))
    else $error("all_outliers inconsistent with kept_count");

  // value ranges of the result
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> filtered_mv_o <= MvW'(MvFullScale)
      && window_mean_mv_o <= MvW'(MvFullScale)
      && duty_percent_o <= PercentW'(PercentScale))
    else $error("output value out of range");

  // duty follows filtered value: filtered/30
  a_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (MvW'(duty_percent_o) * MvW'(DutyDiv) <= filtered_mv_o)
      && (filtered_mv_o < MvW'(duty_percent_o) * MvW'(DutyDiv) + MvW'(DutyDiv)))
    else $error("duty percent does not match filtered value");

endmodule

bind outlier_rejecting_window_average orwa_chk u_orwa_chk (.*);
